// ----- sv/tauv_pkg.sv -----
package tauv_pkg;

   localparam int unsigned INDEX_W = 16;
   localparam int unsigned TEX_W   = 15;
   localparam int unsigned TILE_W  = 13;
   localparam int unsigned MARGIN_W = 12;
   localparam int unsigned GAP_W   = 8;
   localparam int unsigned PITCH_W = 14;
   localparam int unsigned GRID_W  = 15;
   localparam int unsigned PIX_W   = 31;
   localparam int unsigned COORD_W = 17;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 15;

   localparam logic [GRID_W-1:0]  GRID_MAX  = {GRID_W{1'b1}};
   localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXTURE_READY  = 3'd0,
      CSR_TEXTURE_WIDTH  = 3'd1,
      CSR_TEXTURE_HEIGHT = 3'd2,
      CSR_TILE_WIDTH     = 3'd3,
      CSR_TILE_HEIGHT    = 3'd4,
      CSR_EDGE_MARGIN    = 3'd5,
      CSR_TILE_GAP       = 3'd6
   } csr_index_type;

endpackage

// ----- sv/tauv_divider.sv -----
// Restoring divider, one quotient bit per registered stage.
// Caller guarantees the quotient fits in QW bits.
module tauv_divider #(
   parameter int unsigned NW = 16,
   parameter int unsigned DW = 16,
   parameter int unsigned QW = 16,
   parameter int unsigned TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [NW-1:0] out_rem,
   output logic [TW-1:0] out_tag
);

   localparam int unsigned CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

   logic [QW:0]   valid_st;
   logic [NW-1:0] rem_st  [QW+1];
   logic [QW-1:0] quot_st [QW+1];
   logic [DW-1:0] den_st  [QW+1];
   logic [TW-1:0] tag_st  [QW+1];

   assign valid_st[0] = in_valid;
   assign rem_st[0]   = in_num;
   assign quot_st[0]  = '0;
   assign den_st[0]   = in_den;
   assign tag_st[0]   = in_tag;

   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int unsigned Shift = QW - 1 - s;
      logic          valid_ff;
      logic [NW-1:0] rem_ff;
      logic [QW-1:0] quot_ff;
      logic [DW-1:0] den_ff;
      logic [TW-1:0] tag_ff;
      logic [CW-1:0] trial;
      logic          take;

      assign trial = {{(CW-DW){1'b0}}, den_st[s]} << Shift;
      assign take  = {{(CW-NW){1'b0}}, rem_st[s]} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_st[s];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff  <= take ? rem_st[s] - trial[NW-1:0] : rem_st[s];
            quot_ff <= {quot_st[s][QW-2:0], take};
            den_ff  <= den_st[s];
            tag_ff  <= tag_st[s];
         end
      end

      assign valid_st[s+1] = valid_ff;
      assign rem_st[s+1]   = rem_ff;
      assign quot_st[s+1]  = quot_ff;
      assign den_st[s+1]   = den_ff;
      assign tag_st[s+1]   = tag_ff;
   end

   assign out_valid = valid_st[QW];
   assign out_quot  = quot_st[QW];
   assign out_rem   = rem_st[QW];
   assign out_tag   = tag_st[QW];

endmodule

// ----- sv/tile_atlas_uv_generator.sv -----
// Tile atlas UV generator: returns the fixed-point rectangle of a tile inside a
// sprite sheet. Fully pipelined, one tile index per cycle while not stalled.
// Stages: input register, 16-stage grid-size divider, grid register, 16-stage
// index divider, one multiply stage, 17-stage coordinate dividers, output register.
// Grid sizes are derived per item from the registers, so a request may follow a
// register write immediately. A stalled result holds the whole pipeline.
module tile_atlas_uv_generator #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tauv_pkg::INDEX_W-1:0]        req_tile_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_valid_res,
   output logic [tauv_pkg::COORD_W-1:0]        rsp_u_left,
   output logic [tauv_pkg::COORD_W-1:0]        rsp_v_top,
   output logic [tauv_pkg::COORD_W-1:0]        rsp_u_right,
   output logic [tauv_pkg::COORD_W-1:0]        rsp_v_bottom,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tauv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tauv_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tauv_pkg::*;

   localparam int unsigned NUM_W = PIX_W + FRAC_BITS;

   // registers
   logic                ready_ff;
   logic [TEX_W-1:0]    tex_w_ff, tex_h_ff;
   logic [TILE_W-1:0]   tile_w_ff, tile_h_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic [GAP_W-1:0]    gap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         tex_w_ff  <= '0;
         tex_h_ff  <= '0;
         tile_w_ff <= TILE_W'(16);
         tile_h_ff <= TILE_W'(16);
         margin_ff <= '0;
         gap_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TEXTURE_READY:  ready_ff  <= csr_data[0];
            CSR_TEXTURE_WIDTH:  tex_w_ff  <= csr_data[TEX_W-1:0];
            CSR_TEXTURE_HEIGHT: tex_h_ff  <= csr_data[TEX_W-1:0];
            CSR_TILE_WIDTH:     tile_w_ff <= csr_data[TILE_W-1:0];
            CSR_TILE_HEIGHT:    tile_h_ff <= csr_data[TILE_W-1:0];
            CSR_EDGE_MARGIN:    margin_ff <= csr_data[MARGIN_W-1:0];
            CSR_TILE_GAP:       gap_ff    <= csr_data[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   logic enable;
   logic rsp_valid_ff;
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;

   // input stage
   logic               valid_a_ff;
   logic [INDEX_W-1:0] idx_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         idx_a_ff <= req_tile_index;
      end
   end

   // grid size per axis
   logic [15:0]        span_c, span_r, num_c, num_r;
   logic [PITCH_W-1:0] pitch_w, pitch_h, den_c, den_r;
   logic               empty_c, empty_r;

   assign span_c  = {1'b0, tex_w_ff} + {8'b0, gap_ff};
   assign span_r  = {1'b0, tex_h_ff} + {8'b0, gap_ff};
   assign pitch_w = {1'b0, tile_w_ff} + {6'b0, gap_ff};
   assign pitch_h = {1'b0, tile_h_ff} + {6'b0, gap_ff};
   assign empty_c = (span_c <= {4'b0, margin_ff}) || (pitch_w == '0);
   assign empty_r = (span_r <= {4'b0, margin_ff}) || (pitch_h == '0);
   assign num_c   = empty_c ? '0 : span_c - {4'b0, margin_ff};
   assign num_r   = empty_r ? '0 : span_r - {4'b0, margin_ff};
   assign den_c   = empty_c ? PITCH_W'(1) : pitch_w;
   assign den_r   = empty_r ? PITCH_W'(1) : pitch_h;

   logic               g_valid;
   logic [15:0]        g_cols, g_rows;
   logic [INDEX_W+1:0] g_tag;

   tauv_divider #(.NW(16), .DW(PITCH_W), .QW(16), .TW(INDEX_W + 2)) u_grid_c (
      .clock, .reset, .enable,
      .in_valid(valid_a_ff), .in_num(num_c), .in_den(den_c),
      .in_tag({idx_a_ff, empty_c, empty_r}),
      .out_valid(g_valid), .out_quot(g_cols), .out_rem(), .out_tag(g_tag)
   );

   tauv_divider #(.NW(16), .DW(PITCH_W), .QW(16), .TW(1)) u_grid_r (
      .clock, .reset, .enable,
      .in_valid(valid_a_ff), .in_num(num_r), .in_den(den_r), .in_tag(1'b0),
      .out_valid(), .out_quot(g_rows), .out_rem(), .out_tag()
   );

   logic               valid_b_ff;
   logic [INDEX_W-1:0] idx_b_ff;
   logic [GRID_W-1:0]  cols_b_ff, rows_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_b_ff <= g_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         idx_b_ff  <= g_tag[INDEX_W+1:2];
         cols_b_ff <= g_tag[1] ? '0 : (g_cols[15] ? GRID_MAX : g_cols[GRID_W-1:0]);
         rows_b_ff <= g_tag[0] ? '0 : (g_rows[15] ? GRID_MAX : g_rows[GRID_W-1:0]);
      end
   end

   // row and column of the index
   localparam int unsigned TAG2_W = INDEX_W + 2 * GRID_W + 1;
   logic [2*GRID_W-1:0] tiles_b;
   logic [GRID_W-1:0]   cols_den;
   logic                grid_ok_b;

   assign tiles_b   = cols_b_ff * rows_b_ff;
   assign cols_den  = (cols_b_ff == '0) ? GRID_W'(1) : cols_b_ff;
   assign grid_ok_b = (cols_b_ff != '0) && (rows_b_ff != '0);

   logic              x_valid;
   logic [15:0]       x_row, x_col;
   logic [TAG2_W-1:0] x_tag;

   tauv_divider #(.NW(16), .DW(GRID_W), .QW(16), .TW(TAG2_W)) u_index (
      .clock, .reset, .enable,
      .in_valid(valid_b_ff), .in_num(idx_b_ff), .in_den(cols_den),
      .in_tag({idx_b_ff, tiles_b, grid_ok_b}),
      .out_valid(x_valid), .out_quot(x_row), .out_rem(x_col), .out_tag(x_tag)
   );

   logic                   valid_d_ff, ok_d_ff;
   logic [GRID_W+PITCH_W-1:0] pu_d_ff;
   logic [16+PITCH_W-1:0]  pv_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else if (enable) begin
         valid_d_ff <= x_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ok_d_ff <= x_tag[0] &&
                    ({{(2*GRID_W-INDEX_W){1'b0}}, x_tag[TAG2_W-1:2*GRID_W+1]} <
                     x_tag[2*GRID_W:1]);
         pu_d_ff <= x_col[GRID_W-1:0] * pitch_w;
         pv_d_ff <= x_row * pitch_h;
      end
   end

   // pixel positions scaled to fixed point; saturation is detected up front
   logic [PIX_W-1:0] pix_l, pix_t, pix_w, pix_h;
   logic [NUM_W-1:0] num_l, num_t, num_w, num_h, lim_u, lim_v;
   logic             sat_l, sat_t, sat_w, sat_h;

   assign pix_l = {{(PIX_W-MARGIN_W){1'b0}}, margin_ff} +
                  {{(PIX_W-GRID_W-PITCH_W){1'b0}}, pu_d_ff};
   assign pix_t = {{(PIX_W-MARGIN_W){1'b0}}, margin_ff} +
                  {{(PIX_W-16-PITCH_W){1'b0}}, pv_d_ff};
   assign pix_w = {{(PIX_W-TILE_W){1'b0}}, tile_w_ff};
   assign pix_h = {{(PIX_W-TILE_W){1'b0}}, tile_h_ff};
   assign lim_u = {{(NUM_W-TEX_W){1'b0}}, tex_w_ff} << COORD_W;
   assign lim_v = {{(NUM_W-TEX_W){1'b0}}, tex_h_ff} << COORD_W;
   assign sat_l = {pix_l, {FRAC_BITS{1'b0}}} >= lim_u;
   assign sat_t = {pix_t, {FRAC_BITS{1'b0}}} >= lim_v;
   assign sat_w = {pix_w, {FRAC_BITS{1'b0}}} >= lim_u;
   assign sat_h = {pix_h, {FRAC_BITS{1'b0}}} >= lim_v;
   assign num_l = sat_l ? '0 : {pix_l, {FRAC_BITS{1'b0}}};
   assign num_t = sat_t ? '0 : {pix_t, {FRAC_BITS{1'b0}}};
   assign num_w = sat_w ? '0 : {pix_w, {FRAC_BITS{1'b0}}};
   assign num_h = sat_h ? '0 : {pix_h, {FRAC_BITS{1'b0}}};

   logic               f_valid;
   logic [1:0]         f_tag_l;
   logic               f_sat_t, f_sat_w, f_sat_h;
   logic [COORD_W-1:0] q_l, q_t, q_w, q_h;

   tauv_divider #(.NW(NUM_W), .DW(TEX_W), .QW(COORD_W), .TW(2)) u_frac_l (
      .clock, .reset, .enable,
      .in_valid(valid_d_ff), .in_num(num_l), .in_den(tex_w_ff),
      .in_tag({ok_d_ff, sat_l}),
      .out_valid(f_valid), .out_quot(q_l), .out_rem(), .out_tag(f_tag_l)
   );

   tauv_divider #(.NW(NUM_W), .DW(TEX_W), .QW(COORD_W), .TW(1)) u_frac_t (
      .clock, .reset, .enable,
      .in_valid(valid_d_ff), .in_num(num_t), .in_den(tex_h_ff), .in_tag(sat_t),
      .out_valid(), .out_quot(q_t), .out_rem(), .out_tag(f_sat_t)
   );

   tauv_divider #(.NW(NUM_W), .DW(TEX_W), .QW(COORD_W), .TW(1)) u_frac_w (
      .clock, .reset, .enable,
      .in_valid(valid_d_ff), .in_num(num_w), .in_den(tex_w_ff), .in_tag(sat_w),
      .out_valid(), .out_quot(q_w), .out_rem(), .out_tag(f_sat_w)
   );

   tauv_divider #(.NW(NUM_W), .DW(TEX_W), .QW(COORD_W), .TW(1)) u_frac_h (
      .clock, .reset, .enable,
      .in_valid(valid_d_ff), .in_num(num_h), .in_den(tex_h_ff), .in_tag(sat_h),
      .out_valid(), .out_quot(q_h), .out_rem(), .out_tag(f_sat_h)
   );

   // output stage
   logic [COORD_W-1:0] left, top, wfrac, hfrac;
   logic [COORD_W:0]   sum_r, sum_b;
   logic               ok_f;

   assign left  = f_tag_l[0] ? COORD_MAX : q_l;
   assign top   = f_sat_t ? COORD_MAX : q_t;
   assign wfrac = f_sat_w ? COORD_MAX : q_w;
   assign hfrac = f_sat_h ? COORD_MAX : q_h;
   assign sum_r = {1'b0, left} + {1'b0, wfrac};
   assign sum_b = {1'b0, top} + {1'b0, hfrac};
   assign ok_f  = f_tag_l[1] && ready_ff && (tex_w_ff != '0) && (tex_h_ff != '0);

   logic               valid_res_ff;
   logic [COORD_W-1:0] u_left_ff, v_top_ff, u_right_ff, v_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         valid_res_ff <= ok_f;
         u_left_ff    <= ok_f ? left : '0;
         v_top_ff     <= ok_f ? top : '0;
         u_right_ff   <= !ok_f ? '0 : (sum_r[COORD_W] ? COORD_MAX : sum_r[COORD_W-1:0]);
         v_bottom_ff  <= !ok_f ? '0 : (sum_b[COORD_W] ? COORD_MAX : sum_b[COORD_W-1:0]);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = valid_res_ff;
   assign rsp_u_left    = u_left_ff;
   assign rsp_v_top     = v_top_ff;
   assign rsp_u_right   = u_right_ff;
   assign rsp_v_bottom  = v_bottom_ff;

   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         rsp_u_left == '0 && rsp_v_top == '0 && rsp_u_right == '0 && rsp_v_bottom == '0)
      else $error("invalid result carries nonzero coordinates");

   a_edges_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_u_right >= rsp_u_left && rsp_v_bottom >= rsp_v_top)
      else $error("right or bottom edge below left or top edge");

endmodule

// ----- tb/sv/tauv_checker.sv -----
module tauv_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [tauv_pkg::INDEX_W-1:0]    req_tile_index,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_valid_res,
   input  logic [tauv_pkg::COORD_W-1:0]    rsp_u_left,
   input  logic [tauv_pkg::COORD_W-1:0]    rsp_v_top,
   input  logic [tauv_pkg::COORD_W-1:0]    rsp_u_right,
   input  logic [tauv_pkg::COORD_W-1:0]    rsp_v_bottom,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [tauv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tauv_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              rects_pending,
   output int                              rects_checked,
   output int                              rects_in_range,
   output longint                          tile_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tauv_pkg::*;

   localparam int FRAC = 16;

   typedef struct packed {
      logic               in_range;
      logic [COORD_W-1:0] u_left;
      logic [COORD_W-1:0] v_top;
      logic [COORD_W-1:0] u_right;
      logic [COORD_W-1:0] v_bottom;
   } tile_rect_type;

   logic                ready_q;
   logic [TEX_W-1:0]    tex_w_q, tex_h_q;
   logic [TILE_W-1:0]   tile_w_q, tile_h_q;
   logic [MARGIN_W-1:0] margin_q;
   logic [GAP_W-1:0]    gap_q;

   tile_rect_type expected_rects[$];

   function automatic longint axis_tiles(longint tex, longint tile);
      longint span, pitch, q;
      span = tex + gap_q;
      pitch = tile + gap_q;
      if (span <= margin_q || pitch == 0) return 0;
      q = (span - margin_q) / pitch;
      return (q > GRID_MAX) ? longint'(GRID_MAX) : q;
   endfunction

   function automatic longint to_uv(longint pixels, longint tex);
      longint q;
      q = (pixels << FRAC) / tex;
      return (q > COORD_MAX) ? longint'(COORD_MAX) : q;
   endfunction

   function automatic longint sat_sum(longint a, longint b);
      return (a + b > COORD_MAX) ? longint'(COORD_MAX) : a + b;
   endfunction

   function automatic tile_rect_type tile_rect(logic [INDEX_W-1:0] idx);
      tile_rect_type r;
      longint cols, rows, col, row, left, top;
      r = '0;
      cols = axis_tiles(tex_w_q, tile_w_q);
      rows = axis_tiles(tex_h_q, tile_h_q);
      if (!ready_q || tex_w_q == 0 || tex_h_q == 0 || cols == 0 || rows == 0 ||
          idx >= cols * rows) return r;
      col = idx % cols;
      row = idx / cols;
      left = to_uv(margin_q + col * (tile_w_q + gap_q), tex_w_q);
      top = to_uv(margin_q + row * (tile_h_q + gap_q), tex_h_q);
      r.in_range = 1'b1;
      r.u_left = COORD_W'(left);
      r.v_top = COORD_W'(top);
      r.u_right = COORD_W'(sat_sum(left, to_uv(tile_w_q, tex_w_q)));
      r.v_bottom = COORD_W'(sat_sum(top, to_uv(tile_h_q, tex_h_q)));
      return r;
   endfunction

   // number of addressable tiles under the current registers, for stimulus shaping
   always_comb begin
      if (!ready_q || tex_w_q == 0 || tex_h_q == 0) tile_count = 0;
      else tile_count = axis_tiles(tex_w_q, tile_w_q) * axis_tiles(tex_h_q, tile_h_q);
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign rects_pending = expected_rects.size();

   always @(posedge clock) begin
      tile_rect_type want;
      if (reset) begin
         ready_q <= 1'b0;
         tex_w_q <= '0;
         tex_h_q <= '0;
         tile_w_q <= 13'd16;
         tile_h_q <= 13'd16;
         margin_q <= '0;
         gap_q <= '0;
         expected_rects.delete();
         fail_count = 0;
         rects_checked <= 0;
         rects_in_range <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEXTURE_READY:  ready_q <= csr_data[0];
               CSR_TEXTURE_WIDTH:  tex_w_q <= csr_data[TEX_W-1:0];
               CSR_TEXTURE_HEIGHT: tex_h_q <= csr_data[TEX_W-1:0];
               CSR_TILE_WIDTH:     tile_w_q <= csr_data[TILE_W-1:0];
               CSR_TILE_HEIGHT:    tile_h_q <= csr_data[TILE_W-1:0];
               CSR_EDGE_MARGIN:    margin_q <= csr_data[MARGIN_W-1:0];
               CSR_TILE_GAP:       gap_q <= csr_data[GAP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_rects.push_back(tile_rect(req_tile_index));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rects.size() == 0) begin
               $display("%0t result transfer with nothing outstanding", $realtime);
               fail_count++;
            end else begin
               want = expected_rects.pop_front();
               rects_checked <= rects_checked + 1;
               if (want.in_range) rects_in_range <= rects_in_range + 1;
               if (rsp_valid_res !== want.in_range)
                  report_mismatch("valid_res", rsp_valid_res, want.in_range);
               if (rsp_u_left !== want.u_left) report_mismatch("u_left", rsp_u_left, want.u_left);
               if (rsp_v_top !== want.v_top) report_mismatch("v_top", rsp_v_top, want.v_top);
               if (rsp_u_right !== want.u_right)
                  report_mismatch("u_right", rsp_u_right, want.u_right);
               if (rsp_v_bottom !== want.v_bottom)
                  report_mismatch("v_bottom", rsp_v_bottom, want.v_bottom);
            end
         end
      end
   end
endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tauv_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int PIPE_CYCLES = 60;
   localparam int STALL_LIMIT = 3000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [INDEX_W-1:0]    req_tile_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_valid_res;
   logic [COORD_W-1:0]    rsp_u_left, rsp_v_top, rsp_u_right, rsp_v_bottom;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int     fail_count, rects_pending, rects_checked, rects_in_range;
   longint tile_count;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     hold_requests = 0;
   int     hold_seen = 0;
   int     hold_left = 0;
   int     quiet_cycles = 0;
   int     tiles_sent = 0;

   tile_atlas_uv_generator u_dut (.*);

   tauv_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver back-pressure, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_sheet(int unsigned rdy, int unsigned tw, int unsigned th,
                             int unsigned kw, int unsigned kh, int unsigned mg,
                             int unsigned gp);
      write_reg(CSR_TEXTURE_READY, rdy);
      write_reg(CSR_TEXTURE_WIDTH, tw);
      write_reg(CSR_TEXTURE_HEIGHT, th);
      write_reg(CSR_TILE_WIDTH, kw);
      write_reg(CSR_TILE_HEIGHT, kh);
      write_reg(CSR_EDGE_MARGIN, mg);
      write_reg(CSR_TILE_GAP, gp);
      @(posedge clock);
   endtask

   // valid stays up across back-to-back transfers
   task automatic send_tile(logic [INDEX_W-1:0] idx);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_tile_index <= idx;
      do @(posedge clock); while (req_stall);
      tiles_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (rects_pending == 0);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [INDEX_W-1:0] pick_index();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (tile_count == 0 || roll < 10) return INDEX_W'($urandom);
      if (roll < 20) return INDEX_W'(tile_count + $urandom_range(0, 3));
      if (tile_count > 65536) return INDEX_W'($urandom);
      return INDEX_W'($urandom_range(0, int'(tile_count) - 1));
   endfunction

   initial begin
      logic [INDEX_W-1:0] corner[$];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      corner = '{16'd0, 16'd1, 16'd15, 16'd16, 16'd255, 16'd256, 16'hFFFF, 16'hAAAA, 16'h5555};
      // registers at reset: no texture attached
      foreach (corner[i]) send_tile(corner[i]);
      drain();
      load_sheet(1, 256, 256, 16, 16, 0, 0);
      foreach (corner[i]) send_tile(corner[i]);
      drain();
      // one-pixel tiles on the widest sheet, paired with zero-size tiles on the other axis
      load_sheet(1, 32767, 16384, 1, 0, 4095, 255);
      send_tile(16'd0); send_tile(16'hFFFF); send_tile(16'd32767);
      drain();
      load_sheet(1, 16384, 32767, 0, 1, 0, 1);
      send_tile(16'd0); send_tile(16'hFFFF);
      drain();
      // zero texture width, empty axis, unknown register, texture detached
      load_sheet(1, 0, 64, 8, 8, 0, 0);
      send_tile(16'd0);
      drain();
      load_sheet(1, 64, 64, 8191, 8, 4095, 0);
      write_reg(CSR_UNMAPPED, 15'h7FFF);
      send_tile(16'd0);
      drain();
      load_sheet(0, 64, 64, 8, 8, 0, 0);
      send_tile(16'd3);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 8; recv_idle_pct = 70;
         end else if (phase < 6) begin
            send_idle_pct = 70; recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if (phase == 2)
            load_sheet($urandom_range(0, 1), $urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 4095), $urandom_range(0, 255));
         else
            load_sheet(1, $urandom_range(1, 512), $urandom_range(1, 512),
                       $urandom_range(1, 64), $urandom_range(1, 64),
                       $urandom_range(0, 15), $urandom_range(0, 7));
         if (phase == 6) hold_requests++;
         for (int n = 0; n < 100; n++) send_tile(pick_index());
         drain();
      end

      $display("sent %0d tile indexes, checked %0d rectangles (%0d in range)",
               tiles_sent, rects_checked, rects_in_range);
      $display("covered reset, corner and random sheet layouts under mixed back-pressure");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
